FILE: design/brl_pkg.sv
// Shared types and constants for the line rasterizer.
// Depends on nothing; every other design file imports it.
`default_nettype none

package brl_pkg;

    localparam int COORD_BITS  = 16;
    localparam int COLOR_BITS  = 32;

    localparam int PIX_W       = 16;
    localparam int COLOR_W     = 32;
    localparam int DIM_W       = 14;
    localparam int ADDR_W      = 26;
    localparam int ERR_W       = COORD_BITS + 2;
    localparam int CMP_W       = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
    localparam int PROD_W      = COORD_BITS + DIM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic                    command;
        logic signed [PIX_W-1:0] start_x;
        logic signed [PIX_W-1:0] start_y;
        logic signed [PIX_W-1:0] end_x;
        logic signed [PIX_W-1:0] end_y;
        logic [COLOR_W-1:0]      color;
    } cmd_word_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    in_frame;
        logic [ADDR_W-1:0]       pixel_address;
        logic [COLOR_W-1:0]      pixel_color;
        logic                    last;
    } pixel_word_t;

    typedef struct packed {
        logic                    is_load;
        coord_t                  x0;
        coord_t                  y0;
        coord_t                  x1;
        coord_t                  y1;
        logic [COORD_BITS-1:0]   dist_x;
        logic [COORD_BITS-1:0]   dist_y;
        logic                    dir_x_neg;
        logic                    dir_y_neg;
        logic signed [ERR_W-1:0] err;
        logic [COLOR_BITS-1:0]   color;
    } queue_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } frame_cfg_t;

endpackage

`default_nettype wire

FILE: design/brl_front.sv
// Front end: accepts command words and precomputes the line setup.
// Depends on brl_pkg; feeds brl_cmd_queue.
`default_nettype none

module brl_front (
    input  wire                   push,
    input  brl_pkg::cmd_word_t    cmd,
    input  brl_pkg::queue_status_t q_status,
    output logic                  full,
    output logic                  q_push,
    output brl_pkg::queue_entry_t q_entry
);
    import brl_pkg::*;

    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic signed [COORD_BITS:0] dx_s;
    logic signed [COORD_BITS:0] dy_s;
    logic [COORD_BITS:0]        dx_abs;
    logic [COORD_BITS:0]        dy_abs;

    assign x0 = cmd.start_x[COORD_BITS-1:0];
    assign y0 = cmd.start_y[COORD_BITS-1:0];
    assign x1 = cmd.end_x[COORD_BITS-1:0];
    assign y1 = cmd.end_y[COORD_BITS-1:0];

    assign dx_s   = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
    assign dy_s   = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);
    assign dx_abs = (dx_s < 0) ? -dx_s : dx_s;
    assign dy_abs = (dy_s < 0) ? -dy_s : dy_s;

    always_comb
    begin
        q_entry.is_load   = (cmd.command == CMD_LOAD);
        q_entry.x0        = x0;
        q_entry.y0        = y0;
        q_entry.x1        = x1;
        q_entry.y1        = y1;
        q_entry.dist_x    = dx_abs[COORD_BITS-1:0];
        q_entry.dist_y    = dy_abs[COORD_BITS-1:0];
        q_entry.dir_x_neg = !(x0 < x1);
        q_entry.dir_y_neg = !(y0 < y1);
        q_entry.err       = ERR_W'({1'b0, dx_abs[COORD_BITS-1:0]})
                          - ERR_W'({1'b0, dy_abs[COORD_BITS-1:0]});
        q_entry.color     = cmd.color[COLOR_BITS-1:0];
    end

    assign full   = q_status.full;
    assign q_push = push & ~q_status.full;

endmodule

`default_nettype wire

FILE: design/brl_cmd_queue.sv
// Short command queue between the front end and the line stepper.
// Depends on brl_pkg.
`default_nettype none

module brl_cmd_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    wr_en,
    input  brl_pkg::queue_entry_t  wr_entry,
    input  wire                    rd_en,
    output brl_pkg::queue_entry_t  rd_entry,
    output brl_pkg::queue_status_t status
);
    import brl_pkg::*;

    queue_entry_t      entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_wr;
    logic              do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_wr        = wr_en & ~status.full;
    assign do_rd        = rd_en & ~status.empty;
    assign rd_entry     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

FILE: design/brl_back.sv
// Line stepper: runs queued commands against the Bresenham state.
// Depends on brl_pkg; reads brl_cmd_queue and feeds brl_pixel_out.
`default_nettype none

module brl_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  brl_pkg::queue_entry_t  head,
    input  brl_pkg::queue_status_t q_status,
    output logic                   q_pop,
    input  wire                    pix_ready,
    output logic                   pix_valid,
    output brl_pkg::pixel_t        pix
);
    import brl_pkg::*;

    localparam int EW = ERR_W + 1;

    coord_t                  cur_x_reg;
    coord_t                  cur_y_reg;
    coord_t                  target_x_reg;
    coord_t                  target_y_reg;
    logic [COORD_BITS-1:0]   dist_x_reg;
    logic [COORD_BITS-1:0]   dist_y_reg;
    logic                    dir_x_neg_reg;
    logic                    dir_y_neg_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [COLOR_BITS-1:0]   color_reg;
    logic                    busy_reg;
    logic                    pix_valid_reg;
    pixel_t                  pix_reg;

    logic                    do_load;
    logic                    do_emit;
    logic                    at_end;
    logic signed [EW-1:0]    e2;
    logic signed [EW-1:0]    dx_ext;
    logic signed [EW-1:0]    dy_ext;
    logic signed [EW-1:0]    err_ext;
    logic signed [EW-1:0]    err_sum;
    logic                    step_x;
    logic                    step_y;

    assign do_load = ~q_status.empty & head.is_load;
    assign do_emit = ~q_status.empty & ~head.is_load & busy_reg & pix_ready;
    // A step while idle is dropped without waiting for the pixel stage.
    assign q_pop   = ~q_status.empty & (head.is_load | ~busy_reg | pix_ready);

    assign at_end  = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
    assign err_ext = EW'(err_reg);
    assign e2      = {err_ext[EW-2:0], 1'b0};
    assign dx_ext  = EW'({1'b0, dist_x_reg});
    assign dy_ext  = EW'({1'b0, dist_y_reg});
    assign step_x  = (e2 > -dy_ext);
    assign step_y  = (e2 < dx_ext);
    assign err_sum = err_ext - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_load)
            begin
                busy_reg <= 1'b1;
            end
            else if (do_emit && at_end)
            begin
                busy_reg <= 1'b0;
            end
            if (pix_ready)
            begin
                pix_valid_reg <= do_emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            cur_x_reg     <= head.x0;
            cur_y_reg     <= head.y0;
            target_x_reg  <= head.x1;
            target_y_reg  <= head.y1;
            dist_x_reg    <= head.dist_x;
            dist_y_reg    <= head.dist_y;
            dir_x_neg_reg <= head.dir_x_neg;
            dir_y_neg_reg <= head.dir_y_neg;
            err_reg       <= head.err;
            color_reg     <= head.color;
        end
        else if (do_emit && !at_end)
        begin
            if (step_x)
            begin
                cur_x_reg <= dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (step_y)
            begin
                cur_y_reg <= dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
            err_reg <= err_sum[ERR_W-1:0];
        end
        if (do_emit)
        begin
            pix_reg.x     <= cur_x_reg;
            pix_reg.y     <= cur_y_reg;
            pix_reg.color <= color_reg;
            pix_reg.last  <= at_end;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // A line only ends by handing its endpoint to the pixel stage.
    a_end_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (pix_valid_reg && pix_reg.last))
        else $error("line went idle without a last pixel");

    a_pix_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && !pix_ready) |=> (pix_valid_reg && $stable(pix_reg)))
        else $error("stalled pixel changed");

    a_emit_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (do_emit && !at_end) |=> busy_reg)
        else $error("line dropped before its endpoint");

endmodule

`default_nettype wire

FILE: design/brl_pixel_out.sv
// Pixel output stage: clipping, framebuffer address and the result register.
// Depends on brl_pkg; fed by brl_back.
`default_nettype none

module brl_pixel_out (
    input  wire                  clk,
    input  wire                  rst_n,
    input  brl_pkg::frame_cfg_t  cfg,
    input  wire                  pix_valid,
    input  brl_pkg::pixel_t      pix,
    output logic                 pix_ready,
    input  wire                  pop,
    output logic                 empty,
    output brl_pkg::pixel_word_t word
);
    import brl_pkg::*;

    logic [CMP_W-1:0]  xu;
    logic [CMP_W-1:0]  yu;
    logic              in_bounds;
    logic [PROD_W-1:0] addr_full;
    pixel_word_t       word_next;
    pixel_word_t       out_reg;
    logic              out_valid_reg;

    assign xu     = CMP_W'(unsigned'(pix.x));
    assign yu     = CMP_W'(unsigned'(pix.y));
    assign in_bounds = ~pix.x[COORD_BITS-1] && ~pix.y[COORD_BITS-1]
                    && (xu < CMP_W'(cfg.width)) && (yu < CMP_W'(cfg.height));
    assign addr_full = PROD_W'(unsigned'(pix.y)) * PROD_W'(cfg.width)
                     + PROD_W'(unsigned'(pix.x));

    always_comb
    begin
        word_next.pixel_x       = PIX_W'(pix.x);
        word_next.pixel_y       = PIX_W'(pix.y);
        word_next.in_frame      = in_bounds;
        word_next.pixel_address = in_bounds ? addr_full[ADDR_W-1:0] : '0;
        word_next.pixel_color   = COLOR_W'(pix.color);
        word_next.last          = pix.last;
    end

    assign pix_ready = ~out_valid_reg | pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            out_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready && pix_valid)
        begin
            out_reg <= word_next;
        end
    end

    assign empty = ~out_valid_reg;
    assign word  = out_reg;

endmodule

`default_nettype wire

FILE: design/bresenham_line_rasterizer_top.sv
// Top level of the line rasterizer: configuration registers and the pipeline.
// Depends on brl_pkg, brl_front, brl_cmd_queue, brl_back and brl_pixel_out.
// A step word that produces a pixel passes the command queue, the stepper's pixel
// register and the result register before it shows. Throughput: one word per cycle
// while pop keeps the result side free, set by the Bresenham update in the stepper.
// Reset clears the queues, the pixel stage and the busy flag at once; frame width and
// height return to 640 and 480. No clearing pass is needed.
`default_nettype none

module bresenham_line_rasterizer_top (
    input  wire                           clk,
    input  wire                           rst_n,
    // Command side, a queue input: a word is taken when push is high and full is low.
    input  wire                           push,
    output logic                          full,
    input  brl_pkg::cmd_word_t            cmd,
    // Result side, a queue output: the oldest pixel is shown while empty is low.
    output logic                          empty,
    input  wire                           pop,
    output brl_pkg::pixel_word_t          pixel,
    // Configuration port.
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [brl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire [brl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [brl_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import brl_pkg::*;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic             cfg_write;
    frame_cfg_t       cfg;

    queue_status_t    q_status;
    queue_entry_t     q_wr_entry;
    queue_entry_t     q_head;
    logic             q_push;
    logic             q_pop;

    logic             pix_valid;
    logic             pix_ready;
    pixel_t           pix;

    // The port never waits. Registers sit at byte addresses 0 and 4, so bit 2
    // of the address picks the register.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.width  = frame_width_reg;
    assign cfg.height = frame_height_reg;

    // The front end does the line setup arithmetic as a word arrives, so the
    // stepper only loads finished values out of the queue.
    brl_front u_front (
        .push     (push),
        .cmd      (cmd),
        .q_status (q_status),
        .full     (full),
        .q_push   (q_push),
        .q_entry  (q_wr_entry)
    );

    // The queue lets new words arrive while the stepper waits on the output.
    brl_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .rd_en    (q_pop),
        .rd_entry (q_head),
        .status   (q_status)
    );

    // The stepper retires one command per cycle unless a busy step waits on the
    // output side; loads and idle steps never wait for the output side.
    brl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .pix_ready (pix_ready),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    // Clipping and the address multiply sit in their own stage, ahead of the
    // result register.
    brl_pixel_out u_pixel_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_ready (pix_ready),
        .pop       (pop),
        .empty     (empty),
        .word      (pixel)
    );

endmodule

`default_nettype wire
